// ===== sv/ppit_pkg.sv =====
// Shared types and constants for the point-in-polygon tester.
`default_nettype none
package ppit_pkg;

   localparam int COORD_BITS = 16;
   localparam int MAX_VERTS  = 64;
   localparam int CNT_BITS   = $clog2(MAX_VERTS + 1);
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   // edge unit: operand stage, product stage, parity update
   localparam int LAST_STEP  = MAX_VERTS + 2;
   localparam int STEP_BITS  = $clog2(LAST_STEP + 1);
   localparam int MIN_VERTS  = 3;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_TEST   = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } vertex_type;

   typedef struct packed {
      logic [1:0]                   command;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic polygon_valid;
   } rsp_type;

   typedef struct packed {
      logic clear;   // restart parity for a new test
      logic issue;   // an edge is presented this cycle
   } edge_ctl_type;

endpackage
`default_nettype wire

// ===== sv/ppit_cell.sv =====
// One vertex cell of the rotating vertex ring.
`default_nettype none
module ppit_cell (
   input  wire logic               clock,
   input  wire logic               load,
   input  wire logic               shift,
   input  wire ppit_pkg::vertex_type load_vtx,
   input  wire ppit_pkg::vertex_type next_vtx,
   output ppit_pkg::vertex_type    vtx
);

   ppit_pkg::vertex_type vtx_ff;
   ppit_pkg::vertex_type vtx_in;

   always_comb begin
      vtx_in = vtx_ff;
      if (load) begin
         vtx_in = load_vtx;
      end else if (shift) begin
         vtx_in = next_vtx;
      end
   end

   always_ff @(posedge clock) begin
      vtx_ff <= vtx_in;
   end

   assign vtx = vtx_ff;

endmodule
`default_nettype wire

// ===== sv/ppit_edge.sv =====
// Pipelined edge crossing unit with even-odd parity accumulator.
`default_nettype none
module ppit_edge (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ppit_pkg::edge_ctl_type ctl,
   input  wire ppit_pkg::vertex_type  vtx_a,
   input  wire ppit_pkg::vertex_type  vtx_b,
   input  wire ppit_pkg::vertex_type  point,
   output logic                       parity
);

   localparam int DB = ppit_pkg::DIFF_BITS;
   localparam int PB = ppit_pkg::PROD_BITS;

   // operand stage
   logic                 s1_valid_ff, s1_valid_in;
   logic signed [DB-1:0] dyp_ff, dyp_in;   // py - ay
   logic signed [DB-1:0] dxe_ff, dxe_in;   // bx - ax
   logic signed [DB-1:0] dxp_ff, dxp_in;   // px - ax
   logic signed [DB-1:0] dye_ff, dye_in;   // by - ay
   // product stage
   logic                 s2_valid_ff, s2_valid_in;
   logic                 dpos_ff, dpos_in;
   logic signed [PB-1:0] lhs_ff, lhs_in;
   logic signed [PB-1:0] rhs_ff, rhs_in;
   logic                 parity_ff, parity_in;

   logic straddle;
   logic hit;

   always_comb begin
      straddle = ((vtx_a.y < point.y) && (vtx_b.y >= point.y)) ||
                 ((vtx_b.y < point.y) && (vtx_a.y >= point.y));
      s1_valid_in = ctl.issue && straddle;
      dyp_in = DB'(point.y) - DB'(vtx_a.y);
      dxe_in = DB'(vtx_b.x) - DB'(vtx_a.x);
      dxp_in = DB'(point.x) - DB'(vtx_a.x);
      dye_in = DB'(vtx_b.y) - DB'(vtx_a.y);

      s2_valid_in = s1_valid_ff && !ctl.clear;
      dpos_in     = (dye_ff > 0);
      lhs_in      = PB'(dyp_ff) * PB'(dxe_ff);
      rhs_in      = PB'(dxp_ff) * PB'(dye_ff);

      // crossing x strictly left of the point, compared without division
      hit = dpos_ff ? (lhs_ff < rhs_ff) : (rhs_ff < lhs_ff);

      parity_in = parity_ff;
      if (ctl.clear) begin
         parity_in = 1'b0;
      end else if (s2_valid_ff && hit) begin
         parity_in = !parity_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         parity_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in && !ctl.clear;
         s2_valid_ff <= s2_valid_in;
         parity_ff   <= parity_in;
      end
      dyp_ff  <= dyp_in;
      dxe_ff  <= dxe_in;
      dxp_ff  <= dxp_in;
      dye_ff  <= dye_in;
      dpos_ff <= dpos_in;
      lhs_ff  <= lhs_in;
      rhs_ff  <= rhs_in;
   end

   assign parity = parity_ff;

endmodule
`default_nettype wire

// ===== sv/polygon_point_inside_test.sv =====
// Point-in-polygon tester: vertex ring of cells feeding one edge crossing unit.
// Usage:
//   Input beat: start high while busy is low; req_data carries command,
//   coord_x and coord_y. Clear and append never raise busy, so a new beat
//   may follow in the next cycle. An append beyond 64 vertices is dropped.
//   Command code 3 is ignored.
//   A test raises busy while the vertex ring rotates once through all 64
//   cells, one edge per cycle reaching the three-stage crossing unit, and
//   while the last parity update drains from that unit.
//   The result beat appears on rsp_data with rsp_valid high for exactly one
//   cycle, registered at the same edge as busy falls, so the next beat can
//   be accepted at the edge that takes the result. A test always runs the
//   full ring length, and no new beat is taken until it ends.
//   The receiver cannot stall: every result beat is taken when shown.
//   Reset (synchronous, active high) empties the vertex table and returns to
//   idle; vertex contents are not cleared, only the count.
`default_nettype none
module polygon_point_inside_test (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire ppit_pkg::req_type req_data,
   output logic                   rsp_valid,
   output ppit_pkg::rsp_type      rsp_data
);

   localparam int NV = ppit_pkg::MAX_VERTS;
   localparam int CB = ppit_pkg::CNT_BITS;
   localparam int SB = ppit_pkg::STEP_BITS;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type            state_ff, state_in;
   logic [CB-1:0]        count_ff, count_in;
   logic [CB-1:0]        n_ff, n_in;
   logic [SB-1:0]        step_ff, step_in;
   ppit_pkg::vertex_type point_ff, point_in;
   ppit_pkg::vertex_type first_ff, first_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ppit_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   append_en;
   logic                   shift_en;
   ppit_pkg::vertex_type   req_vtx;
   ppit_pkg::vertex_type   cell_vtx [NV];
   ppit_pkg::vertex_type   vtx_b;
   ppit_pkg::edge_ctl_type edge_ctl;
   logic                   parity;

   assign accept    = start && (state_ff == ST_IDLE);
   assign append_en = accept && (req_data.command == ppit_pkg::CMD_APPEND) &&
                      (count_ff < CB'(NV));
   assign shift_en  = (state_ff == ST_RUN) && (step_ff < SB'(NV));
   assign req_vtx.x = req_data.coord_x;
   assign req_vtx.y = req_data.coord_y;

   for (genvar k = 0; k < NV; k++) begin : g_ring
      ppit_cell u_cell (
         .clock    (clock),
         .load     (append_en && (count_ff == CB'(k))),
         .shift    (shift_en),
         .load_vtx (req_vtx),
         .next_vtx (cell_vtx[(k + 1) % NV]),
         .vtx      (cell_vtx[k])
      );
   end

   // closing edge joins the last vertex back to the first
   assign vtx_b = (SB'(n_ff) - SB'(1) == step_ff) ? first_ff : cell_vtx[1];

   always_comb begin
      edge_ctl.clear = accept && (req_data.command == ppit_pkg::CMD_TEST);
      edge_ctl.issue = (state_ff == ST_RUN) && (SB'(n_ff) > step_ff) &&
                       (n_ff >= CB'(ppit_pkg::MIN_VERTS));
   end

   ppit_edge u_edge (
      .clock  (clock),
      .reset  (reset),
      .ctl    (edge_ctl),
      .vtx_a  (cell_vtx[0]),
      .vtx_b  (vtx_b),
      .point  (point_ff),
      .parity (parity)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      step_in      = step_ff;
      point_in     = point_ff;
      first_in     = first_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.command)
                  ppit_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  ppit_pkg::CMD_APPEND: begin
                     if (append_en) begin
                        count_in = count_ff + CB'(1);
                     end
                  end
                  ppit_pkg::CMD_TEST: begin
                     state_in = ST_RUN;
                     n_in     = count_ff;
                     step_in  = '0;
                     point_in = req_vtx;
                     first_in = cell_vtx[0];
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            step_in = step_ff + SB'(1);
            if (step_ff == SB'(ppit_pkg::LAST_STEP)) begin
               state_in                  = ST_IDLE;
               rsp_valid_in              = 1'b1;
               rsp_data_in.inside_res    = parity;
               rsp_data_in.polygon_valid = (n_ff >= CB'(ppit_pkg::MIN_VERTS));
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         n_ff         <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         n_ff         <= n_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      point_ff    <= point_in;
      first_ff    <= first_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff == ST_RUN);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== tb/tb_polygon_point_inside_test.sv =====
// Self-checking testbench for the even-odd point-in-polygon tester.
`default_nettype none
module tb_polygon_point_inside_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 1000;
   localparam int ITEM_TARGET = 1500;
   localparam int SPAN_FULL    = 0;
   localparam int SPAN_TINY    = 1;
   localparam int SPAN_MID     = 2;
   localparam int SPAN_EXTREME = 3;

   // Keeps its own vertex table and queues the verdict of every test beat.
   class verdict_board;
      ppit_pkg::coord_type vx[ppit_pkg::MAX_VERTS];
      ppit_pkg::coord_type vy[ppit_pkg::MAX_VERTS];
      int                  count;
      int                  faults;
      ppit_pkg::rsp_type   due_verdicts[$];

      function new();
         count  = 0;
         faults = 0;
      endfunction

      function int pending();
         return due_verdicts.size();
      endfunction

      // exact crossing test: cross-multiplied instead of dividing by dy
      function bit even_odd_inside(longint px, longint py);
         longint ax, ay, bx, by, d, lhs, rhs;
         int     prev;
         bit     odd;
         odd = 1'b0;
         if (count < ppit_pkg::MIN_VERTS)
            return 1'b0;
         prev = count - 1;
         for (int i = 0; i < count; i++) begin
            ax = vx[i];
            ay = vy[i];
            bx = vx[prev];
            by = vy[prev];
            if ((ay < py && by >= py) || (by < py && ay >= py)) begin
               d   = by - ay;
               lhs = (py - ay) * (bx - ax);
               rhs = (px - ax) * d;
               if (d > 0 ? (lhs < rhs) : (rhs < lhs))
                  odd = !odd;
            end
            prev = i;
         end
         return odd;
      endfunction

      // returns 1 when the beat changes state or yields a verdict
      function bit note_beat(ppit_pkg::req_type beat);
         ppit_pkg::rsp_type verdict;
         case (beat.command)
            ppit_pkg::CMD_CLEAR: begin
               count = 0;
               return 1'b1;
            end
            ppit_pkg::CMD_APPEND: begin
               if (count >= ppit_pkg::MAX_VERTS)
                  return 1'b0;
               vx[count] = beat.coord_x;
               vy[count] = beat.coord_y;
               count++;
               return 1'b1;
            end
            ppit_pkg::CMD_TEST: begin
               verdict.inside_res    = even_odd_inside(beat.coord_x, beat.coord_y);
               verdict.polygon_valid = (count >= ppit_pkg::MIN_VERTS);
               due_verdicts.push_back(verdict);
               return 1'b1;
            end
            default: return 1'b0;
         endcase
      endfunction

      function void check_result(ppit_pkg::rsp_type got);
         ppit_pkg::rsp_type want;
         if (due_verdicts.size() == 0) begin
            $display("%0t: unexpected result beat %b", $time, got);
            faults++;
            return;
         end
         want = due_verdicts.pop_front();
         if (got.inside_res !== want.inside_res) begin
            $display("%0t: inside_res expected %b actual %b",
                     $time, want.inside_res, got.inside_res);
            faults++;
         end
         if (got.polygon_valid !== want.polygon_valid) begin
            $display("%0t: polygon_valid expected %b actual %b",
                     $time, want.polygon_valid, got.polygon_valid);
            faults++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   ppit_pkg::req_type req_data = '0;
   logic              busy;
   logic              rsp_valid;
   ppit_pkg::rsp_type rsp_data;

   verdict_board board = new();
   int items = 0;
   int burst_left = 1;
   int quiet_cycles = 0;

   polygon_point_inside_test uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic idle_for(int n);
      start    <= 1'b0;
      req_data <= ppit_pkg::req_type'({2'($urandom), $urandom});
      repeat (n) @(posedge clock);
   endtask

   // holds start until the beat is taken; busy read here is the pre-edge value
   task automatic drive_beat(ppit_pkg::req_type beat);
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy);
      if (board.note_beat(beat))
         items++;
   endtask

   task automatic send(logic [1:0] cmd, ppit_pkg::coord_type x, ppit_pkg::coord_type y);
      ppit_pkg::req_type beat;
      beat.command = cmd;
      beat.coord_x = x;
      beat.coord_y = y;
      drive_beat(beat);
      burst_left--;
      if (burst_left <= 0) begin
         case ($urandom_range(0, 3))
            0: ;
            1: idle_for($urandom_range(1, 4));
            default: idle_for($urandom_range(1, 90));
         endcase
         burst_left = $urandom_range(1, 24);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   function automatic ppit_pkg::coord_type pick_coord(int span);
      case (span)
         SPAN_TINY: return ppit_pkg::coord_type'(int'($urandom_range(0, 16)) - 8);
         SPAN_MID:  return ppit_pkg::coord_type'(int'($urandom_range(0, 600)) - 300);
         SPAN_EXTREME: begin
            case ($urandom_range(0, 6))
               0: return ppit_pkg::coord_type'(-32768);
               1: return ppit_pkg::coord_type'(-32767);
               2: return ppit_pkg::coord_type'(-1);
               3: return ppit_pkg::coord_type'(0);
               4: return ppit_pkg::coord_type'(1);
               5: return ppit_pkg::coord_type'(32766);
               default: return ppit_pkg::coord_type'(32767);
            endcase
         end
         default: return ppit_pkg::coord_type'($urandom);
      endcase
   endfunction

   function automatic ppit_pkg::coord_type nudge(ppit_pkg::coord_type v);
      return v + ppit_pkg::coord_type'(int'($urandom_range(0, 4)) - 2);
   endfunction

   // probe points cluster on vertices and on their rows and columns so ties get exercised
   task automatic send_probe(int span);
      int                  k;
      ppit_pkg::coord_type px, py;
      k = (board.count > 0) ? $urandom_range(0, board.count - 1) : 0;
      case ((board.count > 0) ? $urandom_range(0, 5) : 5)
         0: begin px = board.vx[k]; py = board.vy[k]; end
         1: begin px = nudge(board.vx[k]); py = nudge(board.vy[k]); end
         2: begin px = pick_coord(span); py = board.vy[k]; end
         3: begin px = board.vx[k]; py = pick_coord(span); end
         4: begin px = pick_coord(SPAN_EXTREME); py = pick_coord(SPAN_EXTREME); end
         default: begin px = pick_coord(span); py = pick_coord(span); end
      endcase
      send(ppit_pkg::CMD_TEST, px, py);
   endtask

   task automatic send_shape();
      int span, nverts, roll;
      span = $urandom_range(SPAN_FULL, SPAN_EXTREME);
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
         repeat ($urandom_range(1, 4))
            send(2'($urandom_range(0, 3)), pick_coord(span), pick_coord(span));
         return;
      end
      if (roll < 92)
         send(ppit_pkg::CMD_CLEAR, pick_coord(SPAN_FULL), pick_coord(SPAN_FULL));
      roll = $urandom_range(0, 99);
      if (roll < 10)
         nverts = $urandom_range(0, 2);
      else if (roll < 16)
         nverts = $urandom_range(60, 70);
      else
         nverts = $urandom_range(3, 12);
      repeat (nverts) begin
         if ($urandom_range(0, 29) == 0)
            send(CMD_UNUSED, pick_coord(span), pick_coord(span));
         send(ppit_pkg::CMD_APPEND, pick_coord(span), pick_coord(span));
      end
      repeat ($urandom_range(2, 8))
         send_probe(span);
      if ($urandom_range(0, 14) == 0)
         drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send(ppit_pkg::CMD_TEST, 16'sd0, 16'sd0);
      send(CMD_UNUSED, -16'sd1, -16'sd1);
      send(ppit_pkg::CMD_APPEND, -16'sd32768, -16'sd32768);
      send(ppit_pkg::CMD_APPEND, 16'sd32767, -16'sd32768);
      send(ppit_pkg::CMD_TEST, 16'sd0, 16'sd0);
      send(ppit_pkg::CMD_APPEND, 16'sd32767, 16'sd32767);
      send(ppit_pkg::CMD_APPEND, -16'sd32768, 16'sd32767);
      send(ppit_pkg::CMD_TEST, 16'sd0, 16'sd0);
      send(ppit_pkg::CMD_TEST, -16'sd32768, 16'sd0);
      send(ppit_pkg::CMD_TEST, 16'sd32767, 16'sd0);
      send(ppit_pkg::CMD_TEST, 16'sd0, -16'sd32768);
      send(ppit_pkg::CMD_TEST, 16'sd0, 16'sd32767);
      send(ppit_pkg::CMD_TEST, 16'sd32767, 16'sd32767);
      send(ppit_pkg::CMD_TEST, -16'sd32768, -16'sd32768);
      send(ppit_pkg::CMD_CLEAR, 16'sd0, 16'sd0);
      send(ppit_pkg::CMD_TEST, 16'sd0, 16'sd0);
      // small triangle with a flat edge: probes inside, on its edges and outside
      send(ppit_pkg::CMD_APPEND, 16'sd0, 16'sd0);
      send(ppit_pkg::CMD_APPEND, 16'sd4, 16'sd0);
      send(ppit_pkg::CMD_APPEND, 16'sd0, 16'sd4);
      send(ppit_pkg::CMD_TEST, 16'sd1, 16'sd1);
      send(ppit_pkg::CMD_TEST, 16'sd0, 16'sd2);
      send(ppit_pkg::CMD_TEST, 16'sd2, 16'sd0);
      send(ppit_pkg::CMD_TEST, 16'sd5, 16'sd5);
      send(ppit_pkg::CMD_TEST, -16'sd1, 16'sd2);
      drain();

      while (items < ITEM_TARGET)
         send_shape();

      drain();
      repeat (ppit_pkg::LAST_STEP + 8) @(posedge clock);
      if (board.faults == 0 && board.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
sv/ppit_pkg.sv
sv/ppit_cell.sv
sv/ppit_edge.sv
sv/polygon_point_inside_test.sv
tb/tb_polygon_point_inside_test.sv
